// ===== rtl/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo pulse slew controller package
// Shared types, codes and constants for the servo pulse slew controller.
// ----------------------------------------------------------------------------
package spsc_pkg;

    // Number of servo channels held in the block
    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Field widths
    localparam int PULSE_W  = 12;
    localparam int PERIOD_W = 10;
    localparam int CFG_IDX_W = 2;

    // Reset values
    localparam logic [PULSE_W-1:0]  MIN_RESET = PULSE_W'(180);
    localparam logic [PULSE_W-1:0]  MAX_RESET = PULSE_W'(900);
    localparam logic [PULSE_W-1:0]  MID_RESET = PULSE_W'(180 + (900 - 180) / 2);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

    // Command kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;

    // Input transaction
    typedef struct packed {
        logic                kind;
        logic [1:0]          channel;
        logic [PULSE_W-1:0]  target_pulse;
        logic [PERIOD_W-1:0] step_period;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [PULSE_W-1:0] pulse_ch0;
        logic [PULSE_W-1:0] pulse_ch1;
        logic [PULSE_W-1:0] pulse_ch2;
        logic [PULSE_W-1:0] pulse_ch3;
        logic [3:0]         busy_mask;
        logic               accepted;
    } t_out;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_SET,
        S_DONE
    } t_state;

endpackage

// ===== rtl/servo_pulse_slew_controller_core.sv =====
// ----------------------------------------------------------------------------
// Servo pulse slew controller core
// Per-channel pulse width slewing towards a clamped target, one shared
// update unit stepping through the channels under a small sequencer.
// ----------------------------------------------------------------------------
// A tick transaction walks the channels one per clock through a single
// shared update unit in the tick state, then passes to the done state, where
// its result is loaded into the output register; a set transaction passes
// through the set state and the done state. The input is stalled until the
// result has been loaded into the output register, that is while the
// sequencer is outside the idle state. A new transaction may be accepted while
// the previous result still waits in the output register. Configuration writes
// are always ready and take effect on the next clock.
module servo_pulse_slew_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  spsc_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output spsc_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spsc_pkg::PULSE_W-1:0]  i_cfg_data
);
    import spsc_pkg::*;

    // Sequencer and command registers
    t_state              r_state, n_state;
    logic [CH_W-1:0]     r_idx;
    t_in                 r_cmd;
    logic                r_acc;
    logic [PULSE_W-1:0]  r_min, r_max;

    // Channel state
    logic [PULSE_W-1:0]  r_cur    [NUM_CHANNELS];
    logic [PULSE_W-1:0]  r_goal   [NUM_CHANNELS];
    logic                r_down   [NUM_CHANNELS];
    logic [PERIOD_W-1:0] r_period [NUM_CHANNELS];
    logic                r_run    [NUM_CHANNELS];
    logic [PERIOD_W-1:0] r_cnt    [NUM_CHANNELS];

    // Output register
    logic                r_out_valid;
    t_out                r_out;

    // Sequencer controls
    logic in_take, tick_we, set_we, out_load, last_idx;

    // Shared unit signals
    logic [CH_W-1:0]     u_addr;
    logic                u_ch_ok;
    logic [PULSE_W-1:0]  u_cur, u_goal, u_nxt_cur, u_clamp_lo, u_clamp;
    logic [PERIOD_W-1:0] u_cnt1;
    logic                u_step;

    logic [PULSE_W-1:0]  pulse_view [4];
    logic [3:0]          busy_view;

    // Channel selected for the shared unit
    always_comb begin
        if (r_state == S_SET) begin
            u_addr = CH_W'(r_cmd.channel);
        end else begin
            u_addr = r_idx;
        end
        u_ch_ok = 32'(r_cmd.channel) < NUM_CHANNELS;
    end

    // Shared update unit: tick counting, stepping and target clamping
    always_comb begin
        u_cur      = r_cur[u_addr];
        u_goal     = r_goal[u_addr];
        u_cnt1     = r_cnt[u_addr] + PERIOD_W'(1);
        u_step     = u_cnt1 >= r_period[u_addr];
        u_nxt_cur  = r_down[u_addr] ? (u_cur - PULSE_W'(1)) : (u_cur + PULSE_W'(1));
        u_clamp_lo = (r_cmd.target_pulse <= r_min) ? r_min : r_cmd.target_pulse;
        u_clamp    = (u_clamp_lo >= r_max) ? r_max : u_clamp_lo;
    end

    assign last_idx = 32'(r_idx) == NUM_CHANNELS - 1;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.kind == KIND_SET) ? S_SET : S_TICK;
                end
            end
            S_TICK: begin
                if (last_idx) begin
                    n_state = S_DONE;
                end
            end
            S_SET: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_take  = 1'b0;
        tick_we  = 1'b0;
        set_we   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_take = i_in_valid;
            end
            S_TICK: begin
                tick_we = r_run[u_addr];
            end
            S_SET: begin
                set_we = u_ch_ok && !r_run[u_addr];
            end
            S_DONE: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                in_take = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;

    // Sequencer registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_acc   <= 1'b0;
            r_min   <= MIN_RESET;
            r_max   <= MAX_RESET;
        end else begin
            r_state <= n_state;
            if (in_take) begin
                r_idx <= '0;
                r_acc <= 1'b0;
            end else if (r_state == S_TICK) begin
                r_idx <= r_idx + CH_W'(1);
            end else if (r_state == S_SET) begin
                r_acc <= set_we;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN_PULSE) begin
                    r_min <= i_cfg_data;
                end else if (i_cfg_index == CFG_MAX_PULSE) begin
                    r_max <= i_cfg_data;
                end
            end
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_in_data;
        end
    end

    // Channel state update through the shared unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cur[c]    <= MID_RESET;
                r_goal[c]   <= MID_RESET;
                r_down[c]   <= 1'b0;
                r_period[c] <= PERIOD_RESET;
                r_run[c]    <= 1'b0;
                r_cnt[c]    <= '0;
            end
        end else if (tick_we) begin
            if (u_cur != u_goal) begin
                if (u_step) begin
                    r_cnt[u_addr] <= '0;
                    r_cur[u_addr] <= u_nxt_cur;
                end else begin
                    r_cnt[u_addr] <= u_cnt1;
                end
            end else begin
                r_run[u_addr] <= 1'b0;
            end
        end else if (set_we) begin
            r_down[u_addr]   <= u_cur >= u_clamp;
            r_goal[u_addr]   <= u_clamp;
            r_period[u_addr] <= r_cmd.step_period;
            r_run[u_addr]    <= 1'b1;
        end
    end

    // Result view of the channels; absent channels read as zero
    for (genvar c = 0; c < 4; c++) begin : g_view
        if (c < NUM_CHANNELS) begin : g_on
            assign pulse_view[c] = r_cur[c];
            assign busy_view[c]  = r_run[c];
        end else begin : g_off
            assign pulse_view[c] = '0;
            assign busy_view[c]  = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pulse_ch0 <= pulse_view[0];
            r_out.pulse_ch1 <= pulse_view[1];
            r_out.pulse_ch2 <= pulse_view[2];
            r_out.pulse_ch3 <= pulse_view[3];
            r_out.busy_mask <= busy_view;
            r_out.accepted  <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A result is only loaded once the sequencer has finished a transaction.
    a_load_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    // A tick pass walks the channels without leaving the tick state.
    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_idx != '0) |-> $past(r_state == S_TICK))
        else $error("tick pass entered mid-way");

    // Only a set command can report acceptance.
    a_acc_set_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_DONE) && r_state == S_IDLE && r_out.accepted)
            |-> r_cmd.kind == KIND_SET)
        else $error("tick reported as accepted");

    // An accepted set leaves its channel running in the same result.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_DONE) && r_state == S_IDLE && r_out.accepted)
            |-> r_out.busy_mask != 4'd0)
        else $error("accepted set without a busy channel");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Servo pulse slew controller testbench
// Drives tick and set-target transactions into the core with random source
// gaps and result back-pressure. It keeps its own model of the four channels
// and the clamp limits, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

    import spsc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_SHOWN     = 10;
    localparam int LONG_HOLD     = 48;

    // Register indexes that the core does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_out                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PULSE_W-1:0]   cfg_data;

    // Channel model
    logic [PULSE_W-1:0]  pw_now     [NUM_CHANNELS];
    logic [PULSE_W-1:0]  pw_goal    [NUM_CHANNELS];
    logic                slew_down  [NUM_CHANNELS];
    logic [PERIOD_W-1:0] step_ticks [NUM_CHANNELS];
    logic                chan_run   [NUM_CHANNELS];
    logic [PERIOD_W-1:0] tick_acc   [NUM_CHANNELS];
    logic [PULSE_W-1:0]  lim_lo;
    logic [PULSE_W-1:0]  lim_hi;

    // Channel status still owed by the core, oldest first
    t_out expected_status_q[$];

    bit idle_en    = 1'b1;
    bit stall_en   = 1'b1;
    int hold_left  = 0;
    int burst_left = 0;

    int err_cnt    = 0;
    int n_items    = 0;
    int n_ticks    = 0;
    int n_sets     = 0;
    int n_taken    = 0;
    int n_results  = 0;
    int n_settings = 0;

    servo_pulse_slew_controller_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the core hangs.
    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", expected_status_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // Pulse value reported for a channel; channels beyond the block read zero.
    function automatic logic [PULSE_W-1:0] pulse_at(input int c);
        if (c < NUM_CHANNELS) begin
            return pw_now[c];
        end
        return '0;
    endfunction

    // Applies one transaction to the channel model and returns the status after it.
    function automatic t_out slew_update(input t_in cmd);
        t_out               st;
        logic [PULSE_W-1:0] g;
        int                 c;
        st = '0;
        if (cmd.kind == KIND_TICK) begin
            for (c = 0; c < NUM_CHANNELS; c++) begin
                if (chan_run[c]) begin
                    if (pw_now[c] != pw_goal[c]) begin
                        tick_acc[c] = tick_acc[c] + PERIOD_W'(1);
                        if (tick_acc[c] >= step_ticks[c]) begin
                            tick_acc[c] = '0;
                            pw_now[c]   = slew_down[c] ? pw_now[c] - PULSE_W'(1)
                                                       : pw_now[c] + PULSE_W'(1);
                        end
                    end else begin
                        chan_run[c] = 1'b0;
                    end
                end
            end
        end else if (int'(cmd.channel) < NUM_CHANNELS && !chan_run[cmd.channel]) begin
            // Raise to the minimum first, then lower to the maximum
            g = cmd.target_pulse;
            if (g <= lim_lo) g = lim_lo;
            if (g >= lim_hi) g = lim_hi;
            slew_down[cmd.channel]  = (pw_now[cmd.channel] >= g);
            pw_goal[cmd.channel]    = g;
            step_ticks[cmd.channel] = cmd.step_period;
            chan_run[cmd.channel]   = 1'b1;
            st.accepted             = 1'b1;
        end
        st.pulse_ch0 = pulse_at(0);
        st.pulse_ch1 = pulse_at(1);
        st.pulse_ch2 = pulse_at(2);
        st.pulse_ch3 = pulse_at(3);
        for (c = 0; c < NUM_CHANNELS && c < 4; c++) begin
            st.busy_mask[c] = chan_run[c];
        end
        return st;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN) begin
                $display("Mismatch in result %0d, %s: expected %0d, got %0d",
                         n_results, name, want, got);
            end
        end
    endtask

    // Result checking, model update on accepted transactions and register writes.
    always @(posedge clk) begin : status_monitor
        t_out want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (expected_status_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN) begin
                        $display("Result %0d arrived with nothing outstanding: %p",
                                 n_results, out_data);
                    end
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("pulse_ch0", 32'(want.pulse_ch0), 32'(out_data.pulse_ch0));
                    check_field("pulse_ch1", 32'(want.pulse_ch1), 32'(out_data.pulse_ch1));
                    check_field("pulse_ch2", 32'(want.pulse_ch2), 32'(out_data.pulse_ch2));
                    check_field("pulse_ch3", 32'(want.pulse_ch3), 32'(out_data.pulse_ch3));
                    check_field("busy_mask", 32'(want.busy_mask), 32'(out_data.busy_mask));
                    check_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
                end
            end
            if (in_valid && !in_stall) begin
                n_items++;
                if (in_data.kind == KIND_TICK) n_ticks++;
                else n_sets++;
                want = slew_update(in_data);
                if (want.accepted) n_taken++;
                expected_status_q.push_back(want);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_PULSE: lim_lo = cfg_data;
                    CFG_MAX_PULSE: lim_hi = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result back-pressure: a long hold when asked for, otherwise random bursts.
    initial begin : result_pacing
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (burst_left > 0) begin
                out_stall <= 1'b1;
                burst_left--;
            end else if (stall_en && $urandom_range(0, 4) == 0) begin
                out_stall  <= 1'b1;
                burst_left = $urandom_range(0, 3);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one transaction and returns at the edge where it is taken.
    task automatic push_item(input t_in cmd);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic push_cmd(input logic kind, input logic [1:0] ch,
                            input logic [PULSE_W-1:0] target,
                            input logic [PERIOD_W-1:0] period);
        t_in cmd;
        cmd.kind         = kind;
        cmd.channel      = ch;
        cmd.target_pulse = target;
        cmd.step_period  = period;
        push_item(cmd);
    endtask

    // Holds the source back until every owed result is in, then lets the core settle.
    task automatic wait_idle();
        int n;
        @(negedge clk);
        in_valid <= 1'b0;
        n = 0;
        while (expected_status_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
        write_reg(CFG_MIN_PULSE, lo);
        write_reg(CFG_MAX_PULSE, hi);
        n_settings++;
    endtask

    // Status straight after reset, with the channel, target and period bits at both values.
    task automatic test_reset_values();
        push_cmd(KIND_TICK, 2'd0, 12'h000, 10'h000);
        push_cmd(KIND_TICK, 2'd3, 12'hFFF, 10'h3FF);
        wait_idle();
    endtask

    // Up and down moves, zero and slow periods, a goal equal to the present
    // value and a set command refused because the channel is still running.
    task automatic test_slew_basics();
        push_cmd(KIND_SET, 2'd0, 12'd542, 10'd0);
        push_cmd(KIND_SET, 2'd1, 12'd538, 10'd1);
        push_cmd(KIND_SET, 2'd2, 12'd540, 10'd1023);
        push_cmd(KIND_SET, 2'd3, 12'd541, 10'd2);
        push_cmd(KIND_TICK, 2'd0, 12'd0, 10'd0);
        push_cmd(KIND_SET, 2'd0, 12'd600, 10'd5);
        repeat (3) push_cmd(KIND_TICK, 2'd0, 12'd0, 10'd0);
        wait_idle();
    endtask

    // Clamping at both limits, a minimum above the maximum, equal limits,
    // writes to unused register indexes and the widest window.
    task automatic test_clamp_limits();
        set_window(12'd530, 12'd550);
        push_cmd(KIND_SET, 2'd0, 12'd0, 10'd0);
        push_cmd(KIND_SET, 2'd1, 12'd4095, 10'd0);
        repeat (2) push_cmd(KIND_TICK, 2'd0, 12'd0, 10'd0);
        wait_idle();
        set_window(12'd560, 12'd520);
        push_cmd(KIND_SET, 2'd2, 12'd700, 10'd1);
        wait_idle();
        set_window(12'd545, 12'd545);
        push_cmd(KIND_SET, 2'd3, 12'd0, 10'd3);
        wait_idle();
        write_reg(CFG_SPARE_A, 12'h000);
        write_reg(CFG_SPARE_B, 12'hFFF);
        set_window(12'd0, 12'd4095);
        repeat (2) push_cmd(KIND_TICK, 2'd1, 12'd0, 10'd0);
        wait_idle();
    endtask

    // The result side holds off for a long stretch while the source keeps
    // offering, so the core fills up and stalls its input.
    task automatic test_backpressure();
        int i;
        idle_en   = 1'b0;
        hold_left = LONG_HOLD;
        for (i = 0; i < 12; i++) begin
            if (i % 4 == 3) push_cmd(KIND_SET, 2'(i), 12'd540, 10'd0);
            else push_cmd(KIND_TICK, 2'd0, 12'd0, 10'd0);
        end
        wait_idle();
        idle_en = 1'b1;
    endtask

    // Random mix of ticks and set commands over several limit settings. Most
    // targets sit close to the present pulse so that moves finish and later
    // set commands are taken; narrow windows also see fully random targets.
    task automatic test_random();
        int lo_tab [6]   = '{180, 500, 0, 600, 530, 500};
        int hi_tab [6]   = '{900, 560, 4095, 520, 530, 580};
        int cnt_tab [6]  = '{150, 150, 120, 100, 80, 150};
        int              p;
        int              i;
        int              t;
        int              mode;
        bit              narrow;
        logic [PULSE_W-1:0] base;
        logic [PULSE_W-1:0] g;
        t_in             cmd;
        for (p = 0; p < 6; p++) begin
            if (p == 5) begin
                idle_en  = 1'b0;
                stall_en = 1'b0;
            end
            set_window(PULSE_W'(lo_tab[p]), PULSE_W'(hi_tab[p]));
            narrow = (hi_tab[p] < lo_tab[p]) || (hi_tab[p] - lo_tab[p] <= 80);
            for (i = 0; i < cnt_tab[p]; i++) begin
                cmd.kind         = ($urandom_range(0, 99) < 55) ? KIND_TICK : KIND_SET;
                cmd.channel      = 2'($urandom_range(0, 3));
                cmd.target_pulse = PULSE_W'($urandom_range(0, 4095));
                cmd.step_period  = PERIOD_W'($urandom_range(0, 1023));
                if (cmd.kind == KIND_SET) begin
                    base = pw_now[cmd.channel];
                    g    = base;
                    if (g <= lim_lo) g = lim_lo;
                    if (g >= lim_hi) g = lim_hi;
                    mode = $urandom_range(0, 9);
                    if (mode < 2 && g == base) begin
                        // Stays put: any period is harmless here
                        cmd.target_pulse = base;
                    end else if (mode < 8 || !narrow) begin
                        t = int'(base) + int'($urandom_range(0, 12)) - 6;
                        if (t < 0) t = 0;
                        if (t > 4095) t = 4095;
                        cmd.target_pulse = PULSE_W'(t);
                        cmd.step_period  = PERIOD_W'($urandom_range(0, 3));
                    end else begin
                        cmd.step_period = PERIOD_W'($urandom_range(0, 3));
                    end
                end
                push_item(cmd);
                if (p < 5 && $urandom_range(0, 59) == 0) wait_idle();
            end
            wait_idle();
        end
    endtask

    initial begin : main_seq
        int c;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        lim_lo    = MIN_RESET;
        lim_hi    = MAX_RESET;
        for (c = 0; c < NUM_CHANNELS; c++) begin
            pw_now[c]     = MID_RESET;
            pw_goal[c]    = MID_RESET;
            slew_down[c]  = 1'b0;
            step_ticks[c] = PERIOD_RESET;
            chan_run[c]   = 1'b0;
            tick_acc[c]   = '0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_slew_basics();
        test_clamp_limits();
        test_backpressure();
        test_random();

        $display("Covered %0d transactions: %0d ticks and %0d set commands, %0d of them taken.",
                 n_items, n_ticks, n_sets, n_taken);
        $display("Checked %0d results over %0d limit settings, with gaps and back-pressure.",
                 n_results, n_settings);
        if (err_cnt == 0 && expected_status_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived.",
                     err_cnt, expected_status_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
